/* hw/rtl/ddd_pkg.sv */
// ---------------------------------------------------------------------------
// Date difference package
// Shared types, constants and the month table of the date difference core.
// ---------------------------------------------------------------------------
package ddd_pkg;

   // Field widths of the command and response words.
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIST_W  = 22;

   // A day count since the base year needs one bit more than the distance.
   localparam int COUNT_W = 23;

   // Width of the days before a month (at most 365).
   localparam int MDAYS_W = 9;

   // Width of a year divided by one hundred (at most 163 for 14-bit years).
   localparam int Q100_W = 8;

   // Width of the leap year count since the base year.
   localparam int LEAPS_W = 12;

   // Years above this value are clipped to it.
   localparam int MAX_YEAR = 9999;

   // Day counts start on the first of January of this year.
   localparam int BASE_YEAR = 1600;

   // Leap years in one through the year before the base year.
   localparam int LEAPS_BEFORE_BASE = 387;

   // Division by one hundred as a multiply by a rounded-up reciprocal.
   // The error stays below 1/256 for every 14-bit operand.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = YEAR_W + RECIP_W;

   localparam int HUNDRED    = 100;
   localparam int YEAR_DAYS  = 365;
   localparam int FEB_MONTH  = 2;
   localparam int LAST_MONTH = 12;

   // One date as it enters a day count pipeline.
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // Days of all months before the given month. Month zero adds nothing and
   // any month past December counts the whole year.
   function automatic logic [MDAYS_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [MDAYS_W-1:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = MDAYS_W'(YEAR_DAYS);
      endcase
      return days;
   endfunction

endpackage

/* hw/rtl/date_difference_days_core.sv */
// ---------------------------------------------------------------------------
// Date difference core
// Returns the absolute number of days between two Gregorian dates.
// ---------------------------------------------------------------------------
//
//   Channel   Handshake          Word
//   --------  -----------------  -------------------------------------------
//   command   start, busy        req_first_*, req_second_* (day, month, year)
//   response  rsp_valid strobe   rsp_day_distance
//
// A command word is taken at each edge with start high; busy stays low, so a
// new word may enter in every cycle. The response strobe and word pass through
// four stages in each day count pipeline and one for the difference.
// Reset clears only the valid bits; words in flight are dropped.
// The response side cannot stall, so the pipeline never holds.
//
module date_difference_days_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ddd_pkg::DAY_W-1:0]    req_first_day,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_first_month,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_first_year,
   input  logic [ddd_pkg::DAY_W-1:0]    req_second_day,
   input  logic [ddd_pkg::MONTH_W-1:0]  req_second_month,
   input  logic [ddd_pkg::YEAR_W-1:0]   req_second_year,
   output logic                         rsp_valid,
   output logic [ddd_pkg::DIST_W-1:0]   rsp_day_distance
);
   import ddd_pkg::*;

   date_type              date_a, date_b;
   logic                  accept;
   logic                  valid_a, valid_b;
   logic [COUNT_W-1:0]    count_a, count_b;

   // The pipeline never backs up, so commands are always taken.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign date_a = '{day: req_first_day, month: req_first_month, year: req_first_year};
   assign date_b = '{day: req_second_day, month: req_second_month, year: req_second_year};

   // One day count pipeline for each date.
   ddd_day_count u_count_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_date   (date_a),
      .out_valid (valid_a),
      .out_count (count_a)
   );

   ddd_day_count u_count_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_date   (date_b),
      .out_valid (valid_b),
      .out_count (count_b)
   );

   // Final stage forms the distance and drives the response strobe.
   ddd_abs_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_a && valid_b),
      .count_a   (count_a),
      .count_b   (count_b),
      .out_valid (rsp_valid),
      .out_dist  (rsp_day_distance)
   );

`ifndef SYNTHESIS
   // Both day count pipelines must stay in lockstep.
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      valid_a == valid_b)
      else $error("day count pipelines out of step");

   // Every accepted command gives a response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("response missing five cycles after a command");

   // No response appears without a valid day count from the first pipeline.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(valid_a, 1))
      else $error("response strobe without a day count");
`endif

endmodule

/* hw/rtl/ddd_day_count.sv */
// ---------------------------------------------------------------------------
// Day count pipeline
// Four register stages that turn one date into its day count since the first
// of January of the base year, in closed form.
// ---------------------------------------------------------------------------
module ddd_day_count (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  ddd_pkg::date_type            in_date,
   output logic                         out_valid,
   output logic [ddd_pkg::COUNT_W-1:0]  out_count
);
   import ddd_pkg::*;

   // Stage 1: clipped year, month table lookup and flags.
   logic                  s1_valid_ff, s1_valid_in;
   logic [YEAR_W-1:0]     s1_year_ff, s1_year_in;
   logic [YEAR_W-1:0]     s1_prev_ff, s1_prev_in;
   logic [YEAR_W-1:0]     s1_elapsed_ff, s1_elapsed_in;
   logic [DAY_W-1:0]      s1_day_ff;
   logic [MDAYS_W-1:0]    s1_mdays_ff, s1_mdays_in;
   logic                  s1_late_ff, s1_late_in;
   logic                  s1_past_ff, s1_past_in;

   // Stage 2: divisions by one hundred and the whole-year days.
   logic                  s2_valid_ff;
   logic [YEAR_W-1:0]     s2_year_ff;
   logic [YEAR_W-1:0]     s2_prev_ff;
   logic [Q100_W-1:0]     s2_qyear_ff, s2_qyear_in;
   logic [Q100_W-1:0]     s2_qprev_ff, s2_qprev_in;
   logic [COUNT_W-1:0]    s2_ydays_ff, s2_ydays_in;
   logic [MDAYS_W:0]      s2_base_ff, s2_base_in;
   logic                  s2_late_ff;
   logic                  s2_past_ff;
   logic [PROD_W-1:0]     prod_year, prod_prev;

   // Stage 3: leap flag and the days of all whole years.
   logic                  s3_valid_ff;
   logic [COUNT_W-1:0]    s3_years_ff, s3_years_in;
   logic [MDAYS_W:0]      s3_base_ff;
   logic                  s3_bonus_ff, s3_bonus_in;
   logic [YEAR_W:0]       hundreds;
   logic                  div100, div400, leap;
   logic [LEAPS_W-1:0]    leaps;

   // Stage 4: final day count.
   logic                  s4_valid_ff;
   logic [COUNT_W-1:0]    s4_count_ff, s4_count_in;

   // Stage 1 logic: clip the year and look up the month.
   always_comb begin
      s1_valid_in = in_valid;
      if (32'(in_date.year) > MAX_YEAR) begin
         s1_year_in = YEAR_W'(MAX_YEAR);
      end else begin
         s1_year_in = in_date.year;
      end
      s1_prev_in    = s1_year_in - YEAR_W'(1);
      s1_elapsed_in = s1_year_in - YEAR_W'(BASE_YEAR);
      s1_past_in    = s1_year_in > YEAR_W'(BASE_YEAR);
      s1_late_in    = in_date.month > MONTH_W'(FEB_MONTH);
      s1_mdays_in   = days_before(in_date.month);
   end

   // Stage 2 logic: reciprocal multiplies and the 365-day years.
   always_comb begin
      prod_year   = PROD_W'(s1_year_ff) * PROD_W'(RECIP_100);
      prod_prev   = PROD_W'(s1_prev_ff) * PROD_W'(RECIP_100);
      s2_qyear_in = prod_year[RECIP_SHIFT +: Q100_W];
      s2_qprev_in = prod_prev[RECIP_SHIFT +: Q100_W];
      s2_ydays_in = COUNT_W'(s1_elapsed_ff) * COUNT_W'(YEAR_DAYS);
      s2_base_in  = (MDAYS_W+1)'(s1_mdays_ff) + (MDAYS_W+1)'(s1_day_ff);
   end

   // Stage 3 logic: leap rule for the year and leap years before it.
   always_comb begin
      hundreds = (YEAR_W+1)'(s2_qyear_ff) * (YEAR_W+1)'(HUNDRED);
      div100   = hundreds == {1'b0, s2_year_ff};
      div400   = div100 && (s2_qyear_ff[1:0] == 2'b00);
      leap     = ((s2_year_ff[1:0] == 2'b00) && !div100) || div400;
      leaps    = LEAPS_W'(s2_prev_ff[YEAR_W-1:2]) - LEAPS_W'(s2_qprev_ff)
               + LEAPS_W'(s2_qprev_ff[Q100_W-1:2]) - LEAPS_W'(LEAPS_BEFORE_BASE);
      s3_bonus_in = s2_late_ff && leap;
      if (s2_past_ff) begin
         s3_years_in = s2_ydays_ff + COUNT_W'(leaps);
      end else begin
         s3_years_in = '0;
      end
   end

   // Stage 4 logic: add the parts of the count.
   assign s4_count_in = s3_years_ff + COUNT_W'(s3_base_ff) + COUNT_W'(s3_bonus_ff);

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Payload registers advance every cycle.
   always_ff @(posedge clock) begin
      s1_year_ff    <= s1_year_in;
      s1_prev_ff    <= s1_prev_in;
      s1_elapsed_ff <= s1_elapsed_in;
      s1_day_ff     <= in_date.day;
      s1_mdays_ff   <= s1_mdays_in;
      s1_late_ff    <= s1_late_in;
      s1_past_ff    <= s1_past_in;

      s2_year_ff  <= s1_year_ff;
      s2_prev_ff  <= s1_prev_ff;
      s2_qyear_ff <= s2_qyear_in;
      s2_qprev_ff <= s2_qprev_in;
      s2_ydays_ff <= s2_ydays_in;
      s2_base_ff  <= s2_base_in;
      s2_late_ff  <= s1_late_ff;
      s2_past_ff  <= s1_past_ff;

      s3_years_ff <= s3_years_in;
      s3_base_ff  <= s2_base_ff;
      s3_bonus_ff <= s3_bonus_in;

      s4_count_ff <= s4_count_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_count = s4_count_ff;

endmodule

/* hw/rtl/ddd_abs_diff.sv */
// ---------------------------------------------------------------------------
// Absolute difference stage
// Registers the absolute difference of two day counts and its strobe.
// ---------------------------------------------------------------------------
module ddd_abs_diff (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ddd_pkg::COUNT_W-1:0]  count_a,
   input  logic [ddd_pkg::COUNT_W-1:0]  count_b,
   output logic                         out_valid,
   output logic [ddd_pkg::DIST_W-1:0]   out_dist
);
   import ddd_pkg::*;

   logic                  valid_ff;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [COUNT_W-1:0]    diff;

   // Subtract the smaller count from the larger one and keep the low bits.
   always_comb begin
      if (count_a >= count_b) begin
         diff = count_a - count_b;
      end else begin
         diff = count_b - count_a;
      end
      dist_in = diff[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign out_valid = valid_ff;
   assign out_dist  = dist_ff;

endmodule
